@@ rtl/sul_pkg.sv @@
package sul_pkg;

    localparam int DATA_W = 32;
    localparam int ACC_W  = 64;
    localparam int EPS_W  = 31;
    localparam int STAT_W = 3;

    typedef enum logic [STAT_W-1:0] {
        ST_SOLVED          = 3'd0,
        ST_CONSISTENT      = 3'd1,
        ST_UNDERDETERMINED = 3'd2,
        ST_CONTRADICTION   = 3'd3,
        ST_ZERO_DIVISOR    = 3'd4
    } status_code_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_MLO,
        S_MHI,
        S_MFIN,
        S_POST,
        S_FINISH,
        S_DIV,
        S_OUTPUT
    } sul_state_t;

    typedef struct packed {
        logic         load;
        logic         mul_load;
        logic         mul_src_p;
        logic         mul_b_v2;
        logic         mul_lo;
        logic         mul_hi;
        logic         mul_fin;
        logic         acc;
        logic         set_seen;
        logic         set_failed;
        logic         scale_from_c;
        logic         scale_from_p;
        logic         div_start;
        logic         div_step;
        logic         out_load;
        logic         clear;
        status_code_t out_code;
    } sul_cmd_t;

    typedef struct packed {
        logic unk1;
        logic unk2;
        logic two;
        logic last;
        logic failed;
        logic seen;
        logic scale_zero;
        logic sum_small;
        logic div_done;
        logic out_free;
    } sul_stat_t;

endpackage

@@ rtl/sul_ctrl.sv @@
module sul_ctrl
    import sul_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output sul_cmd_t  cmd,
    input  sul_stat_t stat
);

    sul_state_t state_reg, state_next;
    logic       second_reg, second_next;
    sul_state_t after_term;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            second_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            second_reg <= second_next;
        end
    end

    assign after_term = stat.last ? S_FINISH : S_IDLE;

    always_comb begin
        cmd         = '0;
        cmd.out_code = ST_SOLVED;
        state_next  = state_reg;
        second_next = second_reg;
        s_ready     = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                second_next = 1'b0;
                if (stat.failed) begin
                    state_next = after_term;
                end else if (stat.unk1 || stat.unk2) begin
                    if (stat.seen || (stat.unk1 && stat.unk2)) begin
                        cmd.set_failed = 1'b1;
                        state_next     = after_term;
                    end else begin
                        cmd.set_seen = 1'b1;
                        if (!stat.two) begin
                            cmd.scale_from_c = 1'b1;
                            state_next       = after_term;
                        end else begin
                            cmd.mul_load = 1'b1;
                            cmd.mul_b_v2 = stat.unk1;
                            state_next   = S_MLO;
                        end
                    end
                end else begin
                    cmd.mul_load = 1'b1;
                    state_next   = S_MLO;
                end
            end
            S_MLO: begin
                cmd.mul_lo = 1'b1;
                state_next = S_MHI;
            end
            S_MHI: begin
                cmd.mul_hi = 1'b1;
                state_next = S_MFIN;
            end
            S_MFIN: begin
                cmd.mul_fin = 1'b1;
                state_next  = S_POST;
            end
            S_POST: begin
                if (stat.unk1 || stat.unk2) begin
                    cmd.scale_from_p = 1'b1;
                    state_next       = after_term;
                end else if (stat.two && !second_reg) begin
                    cmd.mul_load  = 1'b1;
                    cmd.mul_src_p = 1'b1;
                    cmd.mul_b_v2  = 1'b1;
                    second_next   = 1'b1;
                    state_next    = S_MLO;
                end else begin
                    cmd.acc    = 1'b1;
                    state_next = after_term;
                end
            end
            S_FINISH: begin
                if (!stat.failed && stat.seen && !stat.scale_zero) begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end else begin
                    state_next = S_OUTPUT;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_done) begin
                    state_next = S_OUTPUT;
                end
            end
            S_OUTPUT: begin
                if (stat.failed) begin
                    cmd.out_code = ST_UNDERDETERMINED;
                end else if (!stat.seen) begin
                    cmd.out_code = stat.sum_small ? ST_CONSISTENT : ST_CONTRADICTION;
                end else if (stat.scale_zero) begin
                    cmd.out_code = ST_ZERO_DIVISOR;
                end else begin
                    cmd.out_code = ST_SOLVED;
                end
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.clear    = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/sul_dp.sv @@
module sul_dp
    import sul_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  sul_cmd_t                 cmd,
    output sul_stat_t                stat,
    input  logic signed [DATA_W-1:0] s_coefficient,
    input  logic signed [DATA_W-1:0] s_first_value,
    input  logic                     s_first_known,
    input  logic                     s_has_second,
    input  logic signed [DATA_W-1:0] s_second_value,
    input  logic                     s_second_known,
    input  logic                     s_last_term,
    input  logic                     cfg_wr_en,
    input  logic [EPS_W-1:0]         cfg_wr_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [STAT_W-1:0]        m_status,
    output logic signed [DATA_W-1:0] m_solved_value
);

    localparam int NUM_W = ACC_W - 1 + FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W);
    localparam int SH    = DATA_W - FRAC_BITS;
    localparam logic [ACC_W-1:0] SAT_MAG = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] TOP_LIM = SAT_MAG >> SH;
    localparam logic signed [ACC_W:0] POS_LIM = $signed({2'b00, {(ACC_W-1){1'b1}}});
    localparam logic signed [ACC_W:0] NEG_LIM = -POS_LIM;

    function automatic logic [ACC_W-1:0] mag64(input logic [ACC_W-1:0] v);
        mag64 = v[ACC_W-1] ? (~v + ACC_W'(1)) : v;
    endfunction

    logic [DATA_W-1:0] coef_reg, v1_reg, v2_reg;
    logic              k1_reg, two_reg, k2_reg, last_reg;

    logic [ACC_W-1:0]  acc_reg, scale_reg, p_reg;
    logic              seen_reg, failed_reg;
    logic [EPS_W-1:0]  eps_reg;

    logic [ACC_W-1:0]  a_mag_reg;
    logic [DATA_W-1:0] b_mag_reg;
    logic              neg_reg;
    logic [ACC_W-1:0]  lo_reg, top_reg;

    logic [NUM_W-1:0]  num_reg;
    logic [ACC_W-2:0]  den_reg, rem_reg;
    logic [DATA_W:0]   quo_reg;
    logic              ovf_reg, dneg_reg;
    logic [CNT_W-1:0]  cnt_reg;

    logic                    m_valid_reg;
    status_code_t            m_status_reg;
    logic [DATA_W-1:0]       m_value_reg;

    logic [ACC_W-1:0]  coef_ext, a_sel, a_sel_mag;
    logic [DATA_W-1:0] b_sel, b_sel_mag, mul_x;
    logic [ACC_W-1:0]  prod;
    logic [ACC_W:0]    fin_sum;
    logic [ACC_W-1:0]  fin_mag, fin_val;
    logic signed [ACC_W:0] acc_sum;
    logic [ACC_W-1:0]  acc_next;
    logic [ACC_W-1:0]  sum_mag, scale_mag;
    logic [ACC_W-1:0]  rem_sh, rem_diff;
    logic              ge;
    logic [DATA_W:0]   lim;
    logic              over;
    logic [DATA_W-1:0] qmag, sol;

    assign coef_ext  = {{(ACC_W-DATA_W){coef_reg[DATA_W-1]}}, coef_reg};
    assign a_sel     = cmd.mul_src_p ? p_reg : coef_ext;
    assign a_sel_mag = mag64(a_sel);
    assign b_sel     = cmd.mul_b_v2 ? v2_reg : v1_reg;
    assign b_sel_mag = b_sel[DATA_W-1] ? (~b_sel + DATA_W'(1)) : b_sel;
    assign mul_x     = cmd.mul_hi ? a_mag_reg[ACC_W-1:DATA_W] : a_mag_reg[DATA_W-1:0];
    assign prod      = mul_x * b_mag_reg;

    assign fin_sum = {1'b0, top_reg << SH} + {1'b0, lo_reg};
    assign fin_mag = (top_reg > TOP_LIM || fin_sum > {1'b0, SAT_MAG}) ? SAT_MAG
                                                                       : fin_sum[ACC_W-1:0];
    assign fin_val = neg_reg ? (~fin_mag + ACC_W'(1)) : fin_mag;

    assign acc_sum = $signed({acc_reg[ACC_W-1], acc_reg}) + $signed({p_reg[ACC_W-1], p_reg});
    always_comb begin
        if (acc_sum > POS_LIM) begin
            acc_next = POS_LIM[ACC_W-1:0];
        end else if (acc_sum < NEG_LIM) begin
            acc_next = NEG_LIM[ACC_W-1:0];
        end else begin
            acc_next = acc_sum[ACC_W-1:0];
        end
    end

    assign sum_mag   = mag64(acc_reg);
    assign scale_mag = mag64(scale_reg);

    assign rem_sh   = {rem_reg, num_reg[NUM_W-1]};
    assign rem_diff = rem_sh - {1'b0, den_reg};
    assign ge       = rem_sh >= {1'b0, den_reg};

    assign lim  = dneg_reg ? {2'b01, {(DATA_W-1){1'b0}}} : {2'b00, {(DATA_W-1){1'b1}}};
    assign over = ovf_reg || (quo_reg > lim);
    assign qmag = over ? lim[DATA_W-1:0] : quo_reg[DATA_W-1:0];
    assign sol  = dneg_reg ? (~qmag + DATA_W'(1)) : qmag;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            coef_reg <= s_coefficient;
            v1_reg   <= s_first_value;
            k1_reg   <= s_first_known;
            two_reg  <= s_has_second;
            v2_reg   <= s_second_value;
            k2_reg   <= s_second_known;
            last_reg <= s_last_term;
        end
        if (cmd.mul_load) begin
            a_mag_reg <= a_sel_mag;
            b_mag_reg <= b_sel_mag;
            neg_reg   <= a_sel[ACC_W-1] ^ b_sel[DATA_W-1];
        end
        if (cmd.mul_lo) begin
            lo_reg <= prod >> FRAC_BITS;
        end
        if (cmd.mul_hi) begin
            top_reg <= prod;
        end
        if (cmd.mul_fin) begin
            p_reg <= fin_val;
        end
        if (cmd.div_start) begin
            num_reg  <= NUM_W'(sum_mag[ACC_W-2:0]) << FRAC_BITS;
            den_reg  <= scale_mag[ACC_W-2:0];
            rem_reg  <= '0;
            quo_reg  <= '0;
            ovf_reg  <= 1'b0;
            cnt_reg  <= '0;
            dneg_reg <= (acc_reg[ACC_W-1] == scale_reg[ACC_W-1]);
        end else if (cmd.div_step) begin
            num_reg <= num_reg << 1;
            rem_reg <= ge ? rem_diff[ACC_W-2:0] : rem_sh[ACC_W-2:0];
            quo_reg <= {quo_reg[DATA_W-1:0], ge};
            ovf_reg <= ovf_reg | quo_reg[DATA_W];
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
        if (cmd.out_load) begin
            m_status_reg <= cmd.out_code;
            m_value_reg  <= (cmd.out_code == ST_SOLVED) ? sol : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            acc_reg    <= '0;
            scale_reg  <= '0;
            seen_reg   <= 1'b0;
            failed_reg <= 1'b0;
        end else begin
            if (cmd.acc) begin
                acc_reg <= acc_next;
            end
            if (cmd.set_seen) begin
                seen_reg <= 1'b1;
            end
            if (cmd.set_failed) begin
                failed_reg <= 1'b1;
            end
            if (cmd.scale_from_c) begin
                scale_reg <= coef_ext;
            end else if (cmd.scale_from_p) begin
                scale_reg <= p_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg     <= EPS_W'(1);
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                eps_reg <= cfg_wr_data;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.unk1       = !k1_reg;
    assign stat.unk2       = two_reg && !k2_reg;
    assign stat.two        = two_reg;
    assign stat.last       = last_reg;
    assign stat.failed     = failed_reg;
    assign stat.seen       = seen_reg;
    assign stat.scale_zero = (scale_reg == '0);
    assign stat.sum_small  = sum_mag < {{(ACC_W-EPS_W){1'b0}}, eps_reg};
    assign stat.div_done   = (cnt_reg == CNT_W'(NUM_W-1));
    assign stat.out_free   = !m_valid_reg || m_ready;

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_solved_value = m_value_reg;

endmodule

@@ rtl/single_unknown_linear_solver.sv @@
// Single-unknown linear equation solver.
// Input channel s_*: one word per term of sum(c * x [* y]) = 0, with s_last_term
// on the final term. Result channel m_*: one word per equation, sent after the
// last term, carrying m_status and m_solved_value (zero unless status is solved).
// cfg_wr_en / cfg_wr_data write the 31-bit epsilon tolerance; write it only
// while no equation is in progress.
// Work per term, from accept to the next s_ready: no product for a term with
// an unknown and no co-factor, a term that fails the equation or a term after
// failure; one product for a one-factor term or a single product; two for a
// fully known two-factor term. Each product runs as two passes through one
// shared 32x32 multiplier plus a combine step.
// The last term adds a decide state, an output state and, when a solution is
// formed, a run of the restoring divider over the 63 + FRAC_BITS numerator
// bits (one quotient bit per cycle).
// The result sits in an output register; the next equation's terms are taken
// while it waits. If the receiver stalls, the following result waits in the
// controller's output state until the register frees.
// Reset clears the equation state, drops any pending result and sets epsilon to 1.
module single_unknown_linear_solver
    import sul_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [DATA_W-1:0] s_coefficient,
    input  logic signed [DATA_W-1:0] s_first_value,
    input  logic                     s_first_known,
    input  logic                     s_has_second,
    input  logic signed [DATA_W-1:0] s_second_value,
    input  logic                     s_second_known,
    input  logic                     s_last_term,
    input  logic                     cfg_wr_en,
    input  logic [EPS_W-1:0]         cfg_wr_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [STAT_W-1:0]        m_status,
    output logic signed [DATA_W-1:0] m_solved_value
);

    sul_cmd_t  cmd;
    sul_stat_t stat;

    sul_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    sul_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_coefficient  (s_coefficient),
        .s_first_value  (s_first_value),
        .s_first_known  (s_first_known),
        .s_has_second   (s_has_second),
        .s_second_value (s_second_value),
        .s_second_known (s_second_known),
        .s_last_term    (s_last_term),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_solved_value (m_solved_value)
    );

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken again right after accept");

    a_no_result_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result raised directly after an accept");

    a_value_zero_unless_solved: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_SOLVED) |-> m_solved_value == '0)
        else $error("nonzero value on a non-solved result");

endmodule

@@ sim/tb_single_unknown_linear_solver.sv @@
module tb_single_unknown_linear_solver;
    import sul_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     FRAC_BITS      = 16;
    localparam int     CLK_PERIOD     = 12;
    localparam int     RESET_CYCLES   = 6;
    localparam int     SETTLE_CYCLES  = 120;
    localparam int     END_CYCLES     = 200;
    localparam int     WATCHDOG_LIMIT = 5000;
    localparam int     LONG_HOLD      = 400;
    localparam longint SUM_MAX        = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SAT_MAG   = 64'h7FFF_FFFF_FFFF_FFFF;

    localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;
    localparam logic signed [DATA_W-1:0] W_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] W_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        logic signed [DATA_W-1:0] coefficient;
        logic signed [DATA_W-1:0] first_value;
        logic                     first_known;
        logic                     has_second;
        logic signed [DATA_W-1:0] second_value;
        logic                     second_known;
        logic                     last_term;
    } term_t;

    typedef struct {
        status_code_t             status;
        logic signed [DATA_W-1:0] value;
    } outcome_t;

    logic                     aclk           = 1'b0;
    logic                     aresetn        = 1'b0;
    logic                     s_valid        = 1'b0;
    logic                     s_ready;
    logic signed [DATA_W-1:0] s_coefficient  = '0;
    logic signed [DATA_W-1:0] s_first_value  = '0;
    logic                     s_first_known  = 1'b0;
    logic                     s_has_second   = 1'b0;
    logic signed [DATA_W-1:0] s_second_value = '0;
    logic                     s_second_known = 1'b0;
    logic                     s_last_term    = 1'b0;
    logic                     cfg_wr_en      = 1'b0;
    logic [EPS_W-1:0]         cfg_wr_data    = '0;
    logic                     m_valid;
    logic                     m_ready        = 1'b0;
    logic [STAT_W-1:0]        m_status;
    logic signed [DATA_W-1:0] m_solved_value;

    outcome_t         outcomes_due[$];
    logic [EPS_W-1:0] tolerance;
    longint           eq_sum;
    longint           eq_scale;
    logic             eq_seen;
    logic             eq_failed;
    int               failures    = 0;
    int               terms_sent  = 0;
    int               send_idle   = 0;
    int               recv_idle   = 0;
    int               hold_left   = 0;
    int               quiet_count = 0;

    single_unknown_linear_solver #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_coefficient (s_coefficient),
        .s_first_value (s_first_value),
        .s_first_known (s_first_known),
        .s_has_second  (s_has_second),
        .s_second_value(s_second_value),
        .s_second_known(s_second_known),
        .s_last_term   (s_last_term),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_solved_value(m_solved_value)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    function automatic logic [63:0] magnitude_of(longint a);
        return (a < 0) ? 64'(-a) : 64'(a);
    endfunction

    function automatic longint fixed_mul(longint a, longint b);
        logic        neg;
        logic [63:0] ua, ub, top, low, m;
        neg = (a < 0) != (b < 0);
        ua  = magnitude_of(a);
        ub  = magnitude_of(b);
        top = (ua >> 32) * ub;
        low = ((ua & 64'hFFFF_FFFF) * ub) >> FRAC_BITS;
        if (top > (SAT_MAG >> (32 - FRAC_BITS))) begin
            m = SAT_MAG;
        end else begin
            m = top << (32 - FRAC_BITS);
            m = (m > SAT_MAG - low) ? SAT_MAG : m + low;
        end
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint sum_add(longint a, longint b);
        if (b > 0 && a > SUM_MAX - b) return SUM_MAX;
        if (b < 0 && a < -SUM_MAX - b) return -SUM_MAX;
        return a + b;
    endfunction

    function automatic logic [DATA_W-1:0] unknown_value(longint sum, longint scale);
        logic        neg;
        logic [63:0] n, d, lim, q, rem;
        neg = (sum < 0) == (scale < 0);
        n   = magnitude_of(sum);
        d   = magnitude_of(scale);
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        q   = n / d;
        rem = n % d;
        if (q > 64'hFFFF_FFFF) begin
            q = lim;
        end else begin
            for (int i = 0; i < FRAC_BITS; i++) begin
                rem = rem << 1;
                q   = q << 1;
                if (rem >= d) begin
                    rem = rem - d;
                    q   = q | 64'd1;
                end
            end
            if (q > lim) q = lim;
        end
        if (neg) q = -q;
        return q[DATA_W-1:0];
    endfunction

    function automatic void clear_equation();
        eq_sum    = 0;
        eq_scale  = 0;
        eq_seen   = 1'b0;
        eq_failed = 1'b0;
    endfunction

    function automatic void absorb_term(term_t t);
        longint   c, v1, v2, p;
        logic     unk1, unk2;
        outcome_t r;
        c  = t.coefficient;
        v1 = t.first_value;
        v2 = t.second_value;
        if (!eq_failed) begin
            unk1 = !t.first_known;
            unk2 = t.has_second && !t.second_known;
            if (unk1 || unk2) begin
                if (eq_seen || (unk1 && unk2)) begin
                    eq_failed = 1'b1;
                end else begin
                    eq_seen  = 1'b1;
                    eq_scale = t.has_second ? fixed_mul(c, unk1 ? v2 : v1) : c;
                end
            end else begin
                p = fixed_mul(c, v1);
                if (t.has_second) p = fixed_mul(p, v2);
                eq_sum = sum_add(eq_sum, p);
            end
        end
        if (!t.last_term) return;
        r.value = '0;
        if (eq_failed) begin
            r.status = ST_UNDERDETERMINED;
        end else if (!eq_seen) begin
            r.status = (magnitude_of(eq_sum) < {33'd0, tolerance}) ? ST_CONSISTENT
                                                                 : ST_CONTRADICTION;
        end else if (eq_scale == 0) begin
            r.status = ST_ZERO_DIVISOR;
        end else begin
            r.status = ST_SOLVED;
            r.value  = unknown_value(eq_sum, eq_scale);
        end
        outcomes_due = {outcomes_due, r};
        clear_equation();
    endfunction

    always @(posedge aclk) begin : result_check
        outcome_t want;
        if (m_valid && m_ready) begin
            if (outcomes_due.size() == 0) begin
                $error("unexpected result: m_status %0d, m_solved_value %0d",
                       m_status, m_solved_value);
                failures++;
            end else begin
                want = outcomes_due.pop_front();
                if (m_status !== want.status) begin
                    $error("m_status: expected %0d, actual %0d", want.status, m_status);
                    failures++;
                end
                if (m_solved_value !== want.value) begin
                    $error("m_solved_value: expected %0d, actual %0d",
                           want.value, m_solved_value);
                    failures++;
                end
            end
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_count <= 0;
        end else if (quiet_count >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_count <= quiet_count + 1;
        end
    end

    task automatic send_term(input term_t t);
        while ($urandom_range(0, 99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_coefficient  <= t.coefficient;
        s_first_value  <= t.first_value;
        s_first_known  <= t.first_known;
        s_has_second   <= t.has_second;
        s_second_value <= t.second_value;
        s_second_known <= t.second_known;
        s_last_term    <= t.last_term;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        absorb_term(t);
        terms_sent++;
    endtask

    task automatic stop_sending();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_results();
        while (outcomes_due.size() != 0) @(posedge aclk);
    endtask

    task automatic write_epsilon(input logic [EPS_W-1:0] value);
        stop_sending();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        tolerance = value;
    endtask

    function automatic term_t mk(logic signed [DATA_W-1:0] c, logic signed [DATA_W-1:0] v1,
                                 logic k1, logic two, logic signed [DATA_W-1:0] v2,
                                 logic k2, logic last);
        term_t t;
        t.coefficient  = c;
        t.first_value  = v1;
        t.first_known  = k1;
        t.has_second   = two;
        t.second_value = v2;
        t.second_known = k2;
        t.last_term    = last;
        return t;
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_word();
        logic signed [DATA_W-1:0] w;
        case ($urandom_range(0, 9))
            0: w = '0;
            1: w = W_MIN;
            2: w = W_MAX;
            3, 4, 5: w = $urandom;
            default: begin
                w = $urandom_range(0, 32'h0004_0000);
                if ($urandom_range(0, 1)) w = -w;
            end
        endcase
        return w;
    endfunction

    function automatic term_t known_term();
        term_t t;
        t.coefficient  = rand_word();
        t.first_value  = rand_word();
        t.first_known  = 1'b1;
        t.has_second   = ($urandom_range(0, 2) == 0);
        t.second_value = rand_word();
        t.second_known = t.has_second ? 1'b1 : 1'($urandom_range(0, 1));
        t.last_term    = 1'b0;
        return t;
    endfunction

    function automatic term_t make_unknown(term_t t);
        if (!t.has_second || $urandom_range(0, 1)) t.first_known = 1'b0;
        else t.second_known = 1'b0;
        return t;
    endfunction

    task automatic send_random_equation();
        term_t eq[$];
        int    n, kind, at, at2;
        n    = $urandom_range(1, 5);
        kind = $urandom_range(0, 99);
        for (int i = 0; i < n; i++) eq = {eq, known_term()};
        at = $urandom_range(0, n - 1);
        if (kind < 50) begin
            eq[at] = make_unknown(eq[at]);
        end else if (kind < 70) begin
            if (n >= 2 && $urandom_range(0, 1)) begin
                eq[1] = eq[0];
                eq[1].coefficient = -eq[0].coefficient;
            end
        end else if (kind < 80) begin
            eq = {eq, known_term()};
            at2 = $urandom_range(0, n);
            if (at2 == at) at2 = (at + 1) % (n + 1);
            eq[at]  = make_unknown(eq[at]);
            eq[at2] = make_unknown(eq[at2]);
        end else if (kind < 88) begin
            eq[at].has_second   = 1'b1;
            eq[at].first_known  = 1'b0;
            eq[at].second_known = 1'b0;
        end else if (kind < 95) begin
            eq[at] = make_unknown(eq[at]);
            eq[at].coefficient = '0;
        end else begin
            foreach (eq[i]) begin
                eq[i].first_known  = 1'($urandom_range(0, 1));
                eq[i].has_second   = 1'($urandom_range(0, 1));
                eq[i].second_known = 1'($urandom_range(0, 1));
            end
        end
        eq[eq.size() - 1].last_term = 1'b1;
        foreach (eq[i]) send_term(eq[i]);
    endtask

    task automatic test_directed();
        send_term(mk('0, W_MAX, 1'b1, 1'b0, '0, 1'b0, 1'b1));
        send_term(mk(Q_ONE, Q_ONE, 1'b1, 1'b0, '0, 1'b0, 1'b1));
        send_term(mk(2 * Q_ONE, 3 * Q_ONE, 1'b1, 1'b0, 32'sh1234_5678, 1'b0, 1'b0));
        send_term(mk(2 * Q_ONE, '0, 1'b0, 1'b0, '0, 1'b0, 1'b1));
        send_term(mk('0, '0, 1'b0, 1'b0, '0, 1'b0, 1'b1));
        send_term(mk(32'sd1, 32'sd1, 1'b1, 1'b1, '0, 1'b0, 1'b1));
        send_term(mk(5 * Q_ONE, '0, 1'b0, 1'b0, '0, 1'b0, 1'b0));
        send_term(mk(7 * Q_ONE, '0, 1'b0, 1'b0, '0, 1'b0, 1'b0));
        send_term(mk(W_MIN, W_MIN, 1'b1, 1'b1, W_MIN, 1'b1, 1'b0));
        send_term(mk(W_MAX, W_MAX, 1'b0, 1'b1, W_MAX, 1'b0, 1'b1));
        send_term(mk(Q_ONE, '0, 1'b0, 1'b1, '0, 1'b0, 1'b0));
        send_term(mk(Q_ONE, Q_ONE, 1'b1, 1'b0, '0, 1'b0, 1'b1));
        repeat (4) send_term(mk(W_MIN, W_MIN, 1'b1, 1'b1, W_MIN, 1'b1, 1'b0));
        send_term(mk(Q_ONE, '0, 1'b0, 1'b1, Q_ONE, 1'b1, 1'b1));
        repeat (4) send_term(mk(W_MAX, W_MIN, 1'b1, 1'b1, W_MIN, 1'b1, 1'b0));
        send_term(mk(W_MAX, W_MAX, 1'b1, 1'b1, '0, 1'b0, 1'b1));
    endtask

    task automatic test_random(input int n_terms, input int s_idle, input int r_idle);
        int stop_at;
        stop_at   = terms_sent + n_terms;
        send_idle = s_idle;
        recv_idle = r_idle;
        while (terms_sent < stop_at) send_random_equation();
    endtask

    task automatic test_backpressure();
        send_idle = 0;
        recv_idle = 0;
        hold_left = LONG_HOLD;
        repeat (5) begin
            send_term(mk(Q_ONE, 2 * Q_ONE, 1'b1, 1'b0, '0, 1'b0, 1'b0));
            send_term(mk(Q_ONE, '0, 1'b0, 1'b0, '0, 1'b0, 1'b1));
        end
        stop_sending();
        wait_results();
        repeat (3) send_random_equation();
    endtask

    initial begin
        tolerance = EPS_W'(1);
        clear_equation();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        write_epsilon('0);
        test_random(230, 36, 59);
        write_epsilon({EPS_W{1'b1}});
        test_random(230, 59, 36);
        write_epsilon(EPS_W'($urandom_range(0, 32'h0004_0000)));
        test_random(200, 0, 0);
        test_backpressure();
        write_epsilon(EPS_W'($urandom));
        test_random(60, 0, 0);

        stop_sending();
        wait_results();
        repeat (END_CYCLES) @(posedge aclk);
        if (failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
